FILE: sv/rtfe_pkg.sv
// ----------------------------------------------------------------------------
// rtfe_pkg
// Shared types and constants for the RF temperature frame encoder.
// ----------------------------------------------------------------------------
package rtfe_pkg;

  // Field widths
  localparam int unsigned READING_W = 12;
  localparam int unsigned MAG_W     = 11;   // clamped magnitude, at most 2000
  localparam int unsigned PADDR_W   = 4;    // four 32-bit registers
  localparam int unsigned PDATA_W   = 32;

  // Line format
  localparam int unsigned FRAME_BYTES    = 9;
  localparam int unsigned FRAME_BITS     = 8 * FRAME_BYTES;
  localparam int unsigned PREAMBLE_BITS  = 16;
  localparam int unsigned POSTAMBLE_BITS = 8;
  localparam int unsigned MSG_BITS       = PREAMBLE_BITS + FRAME_BITS + POSTAMBLE_BITS;
  localparam int unsigned MSG_UNITS      = 4 * MSG_BITS;
  localparam int unsigned POS_W          = $clog2(MSG_UNITS);
  localparam int unsigned BIT_IDX_W      = POS_W - 2;
  localparam int unsigned FBIT_W         = $clog2(FRAME_BITS);

  localparam int unsigned PAUSE_UNITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // Reading limits
  localparam logic signed [READING_W-1:0] READING_MIN = -12'sd880;
  localparam logic signed [READING_W-1:0] READING_MAX = 12'sd2000;

  // Frame constants
  localparam logic [3:0] BATT_LOW_NIBBLE = 4'hC;
  localparam logic [7:0] NEG_MARK        = 8'h08;
  localparam logic [7:0] CHECK_BIAS      = 8'h0A;

  // Register reset values
  localparam logic [15:0] SENSOR_TYPE_RST  = 16'd6701;
  localparam logic [7:0]  CHANNEL_CODE_RST = 8'd32;
  localparam logic [7:0]  ROLLING_ID_RST   = 8'd187;
  localparam logic        BATTERY_OK_RST   = 1'b0;

  typedef enum logic [1:0] {
    REG_SENSOR_TYPE  = 2'd0,
    REG_CHANNEL_CODE = 2'd1,
    REG_ROLLING_ID   = 2'd2,
    REG_BATTERY_OK   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] sensor_type;
    logic [7:0]  channel_code;
    logic [7:0]  rolling_id;
    logic        battery_ok;
  } cfg_t;

  // What the front decided an item is
  typedef enum logic [1:0] {
    OP_IDLE   = 2'd0,   // tick with nothing to send
    OP_START  = 2'd1,   // new transmission
    OP_IGNORE = 2'd2,   // start while busy, dropped
    OP_UNIT   = 2'd3    // one line unit of an active transmission
  } op_code_t;

  typedef struct packed {
    op_code_t         op;
    logic             last;
    logic             quiet;   // unit lies in the gap between messages
    logic [POS_W-1:0] pos;     // unit position within one message
    logic             neg;
    logic [MAG_W-1:0] mag;
  } q_entry_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_end;
    logic start_ignored;
  } res_t;

endpackage

FILE: sv/rtfe_in_if.sv
// ----------------------------------------------------------------------------
// rtfe_in_if
// Input item channel: valid/ready with action and raw reading.
// ----------------------------------------------------------------------------
interface rtfe_in_if import rtfe_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic signed [READING_W-1:0] sensor_reading;

  modport source (output valid, action, sensor_reading, input ready);
  modport sink   (input valid, action, sensor_reading, output ready);
endinterface

FILE: sv/rtfe_out_if.sv
// ----------------------------------------------------------------------------
// rtfe_out_if
// Result item channel: valid/ready with line level and status flags.
// ----------------------------------------------------------------------------
interface rtfe_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic frame_end;
  logic start_ignored;

  modport source (output valid, line_level, busy_res, frame_end, start_ignored,
                  input ready);
  modport sink   (input valid, line_level, busy_res, frame_end, start_ignored,
                  output ready);
endinterface

FILE: sv/rtfe_cfg_regs.sv
// ----------------------------------------------------------------------------
// rtfe_cfg_regs
// APB-style configuration registers: type, channel, id, battery flag.
// ----------------------------------------------------------------------------
module rtfe_cfg_regs import rtfe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t     cfg_r, cfg_nxt;
  cfg_reg_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_SENSOR_TYPE:  cfg_nxt.sensor_type  = pwdata[15:0];
        REG_CHANNEL_CODE: cfg_nxt.channel_code = pwdata[7:0];
        REG_ROLLING_ID:   cfg_nxt.rolling_id   = pwdata[7:0];
        REG_BATTERY_OK:   cfg_nxt.battery_ok   = pwdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SENSOR_TYPE:  prdata = {16'd0, cfg_r.sensor_type};
      REG_CHANNEL_CODE: prdata = {24'd0, cfg_r.channel_code};
      REG_ROLLING_ID:   prdata = {24'd0, cfg_r.rolling_id};
      REG_BATTERY_OK:   prdata = {31'd0, cfg_r.battery_ok};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensor_type  <= SENSOR_TYPE_RST;
      cfg_r.channel_code <= CHANNEL_CODE_RST;
      cfg_r.rolling_id   <= ROLLING_ID_RST;
      cfg_r.battery_ok   <= BATTERY_OK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/rtfe_front.sv
// ----------------------------------------------------------------------------
// rtfe_front
// Accepts items, tracks the transmission position and classifies each item.
// ----------------------------------------------------------------------------
module rtfe_front import rtfe_pkg::*; #(
  parameter int unsigned PAUSE_UNITS = PAUSE_UNITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic signed [READING_W-1:0] in_reading,
  output logic                        push_valid,
  output q_entry_t                    push_entry,
  input  logic                        push_ready
);

  localparam int unsigned TOTAL_UNITS = 2 * MSG_UNITS + PAUSE_UNITS;
  localparam int unsigned CNT_W       = $clog2(TOTAL_UNITS);
  localparam logic [CNT_W-1:0] LAST_UNIT    = CNT_W'(TOTAL_UNITS - 1);
  localparam logic [CNT_W-1:0] PAUSE_START  = CNT_W'(MSG_UNITS);
  localparam logic [CNT_W-1:0] REPEAT_START = CNT_W'(MSG_UNITS + PAUSE_UNITS);

  logic                        sending_r, sending_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        accept;
  logic signed [READING_W-1:0] clamped;
  logic [READING_W-1:0]        mag_full;
  logic [CNT_W-1:0]            repeat_pos;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid & push_ready;

  always_comb begin
    if (in_reading < READING_MIN) begin
      clamped = READING_MIN;
    end else if (in_reading > READING_MAX) begin
      clamped = READING_MAX;
    end else begin
      clamped = in_reading;
    end
    mag_full = clamped[READING_W-1] ? READING_W'(-clamped) : READING_W'(clamped);
  end

  assign repeat_pos = cnt_r - REPEAT_START;

  // classification
  always_comb begin
    push_entry       = '0;
    push_entry.op    = OP_IDLE;
    push_entry.neg   = clamped[READING_W-1];
    push_entry.mag   = mag_full[MAG_W-1:0];
    if (in_action) begin
      push_entry.op = sending_r ? OP_IGNORE : OP_START;
    end else if (sending_r) begin
      push_entry.op   = OP_UNIT;
      push_entry.last = (cnt_r == LAST_UNIT);
      if (cnt_r < PAUSE_START) begin
        push_entry.pos = cnt_r[POS_W-1:0];
      end else if (cnt_r < REPEAT_START) begin
        push_entry.quiet = 1'b1;
      end else begin
        push_entry.pos = repeat_pos[POS_W-1:0];
      end
    end
  end

  always_comb begin
    sending_nxt = sending_r;
    cnt_nxt     = cnt_r;
    if (accept) begin
      if (in_action) begin
        if (!sending_r) begin
          sending_nxt = 1'b1;
          cnt_nxt     = '0;
        end
      end else if (sending_r) begin
        if (cnt_r == LAST_UNIT) begin
          sending_nxt = 1'b0;
          cnt_nxt     = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      sending_r <= sending_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> cnt_r == '0)
    else $error("unit counter nonzero while idle");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_UNIT)
    else $error("unit counter past end of transmission");

  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action && !sending_r) |=> (sending_r && cnt_r == '0))
    else $error("start did not arm the transmitter");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_action && sending_r && cnt_r == LAST_UNIT) |=> !sending_r)
    else $error("transmission did not end on its last unit");

endmodule

FILE: sv/rtfe_queue.sv
// ----------------------------------------------------------------------------
// rtfe_queue
// Small register FIFO decoupling the front from the back.
// ----------------------------------------------------------------------------
module rtfe_queue import rtfe_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  q_entry_t push_entry,
  output logic     pop_valid,
  input  logic     pop_ready,
  output q_entry_t pop_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_entry_t         entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = entry_r[rd_ptr_r];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == FULL_CNT) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a push");

endmodule

FILE: sv/rtfe_back.sv
// ----------------------------------------------------------------------------
// rtfe_back
// Frame arithmetic pipeline, frame store and line serializer.
// ----------------------------------------------------------------------------
module rtfe_back import rtfe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     q_valid,
  output logic     q_ready,
  input  q_entry_t q_entry,
  output logic     out_valid,
  input  logic     out_ready,
  output res_t     out_res
);

  typedef struct packed {
    op_code_t         op;
    logic             last;
    logic             quiet;
    logic [POS_W-1:0] pos;
    logic             neg;
    logic [13:0]      centi;
    logic [6:0]       whole;
    logic [6:0]       rem;
    logic [3:0]       tens;
    logic [3:0]       units;
    logic [3:0]       tenths;
  } stage_t;

  // reciprocal multipliers: floor(x/100) for x < 43690, floor(x/10) for x < 1024
  localparam logic [26:0] RECIP_100 = 27'd5243;
  localparam logic [14:0] RECIP_10  = 15'd205;
  localparam logic [13:0] HUNDRED   = 14'd100;
  localparam logic [6:0]  TEN       = 7'd10;
  localparam logic [7:0]  ROUND_5   = 8'd5;

  logic                  en;
  logic                  s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  stage_t                s1_r, s2_r, s3_r, s4_r;
  stage_t                s1_nxt, s2_nxt, s3_nxt, s4_nxt;
  logic [FRAME_BITS-1:0] frame_r;
  logic [FRAME_BITS-1:0] frame_nxt;
  logic                  out_valid_r;
  res_t                  res_r, res_nxt;

  logic [26:0]           q100_prod;
  logic [13:0]           rem_full;
  logic [14:0]           tens_prod;
  logic [6:0]            units_full;
  logic [14:0]           tenths_prod;
  logic [7:0]            byte4, byte5, byte6;
  logic [63:0]           body;
  logic [7:0]            sum_lo, sum_hi, check;
  logic [BIT_IDX_W-1:0]  bit_idx;
  logic [BIT_IDX_W-1:0]  fbit_full;
  logic                  data_bit;

  // whole pipe moves together; stalls only when the output slot is held
  assign en      = !out_valid_r || out_ready;
  assign q_ready = en;

  // centi-degrees: 6m + m/4
  always_comb begin
    s1_nxt       = '0;
    s1_nxt.op    = q_entry.op;
    s1_nxt.last  = q_entry.last;
    s1_nxt.quiet = q_entry.quiet;
    s1_nxt.pos   = q_entry.pos;
    s1_nxt.neg   = q_entry.neg;
    s1_nxt.centi = ({3'd0, q_entry.mag} << 2) + ({3'd0, q_entry.mag} << 1)
                 + {5'd0, q_entry.mag[MAG_W-1:2]};
  end

  // whole degrees
  assign q100_prod = 27'(s1_r.centi) * RECIP_100;
  always_comb begin
    s2_nxt       = s1_r;
    s2_nxt.whole = q100_prod[25:19];
  end

  // remainder and tens digit
  assign rem_full  = s2_r.centi - ({7'd0, s2_r.whole} * HUNDRED);
  assign tens_prod = 15'(s2_r.whole) * RECIP_10;
  always_comb begin
    s3_nxt      = s2_r;
    s3_nxt.rem  = rem_full[6:0];
    s3_nxt.tens = tens_prod[14:11];
  end

  // units digit and rounded tenths
  assign units_full  = s3_r.whole - ({3'd0, s3_r.tens} * TEN);
  assign tenths_prod = 15'({1'b0, s3_r.rem} + ROUND_5) * RECIP_10;
  always_comb begin
    s4_nxt        = s3_r;
    s4_nxt.units  = units_full[3:0];
    s4_nxt.tenths = tenths_prod[14:11];
  end

  // frame assembly and checksum
  always_comb begin
    byte4 = {s4_r.tenths, cfg.battery_ok ? 4'h0 : BATT_LOW_NIBBLE};
    byte5 = {s4_r.tens, s4_r.units};
    byte6 = s4_r.neg ? NEG_MARK : 8'h00;
    body  = {8'h00, byte6, byte5, byte4, cfg.rolling_id, cfg.channel_code,
             cfg.sensor_type[7:0], cfg.sensor_type[15:8]};
    sum_lo = '0;
    sum_hi = '0;
    for (int i = 0; i < 8; i++) begin
      sum_lo = sum_lo + {4'd0, body[4*i +: 4]};
      sum_hi = sum_hi + {4'd0, body[32 + 4*i +: 4]};
    end
    check     = sum_lo + sum_hi - CHECK_BIAS;
    frame_nxt = {check, body};
  end

  // serializer: preamble ones, frame LSB first, postamble zeros
  assign bit_idx   = s4_r.pos[POS_W-1:2];
  assign fbit_full = bit_idx - BIT_IDX_W'(PREAMBLE_BITS);
  always_comb begin
    if (bit_idx < BIT_IDX_W'(PREAMBLE_BITS)) begin
      data_bit = 1'b1;
    end else if (bit_idx < BIT_IDX_W'(PREAMBLE_BITS + FRAME_BITS)) begin
      data_bit = frame_r[fbit_full[FBIT_W-1:0]];
    end else begin
      data_bit = 1'b0;
    end
  end

  always_comb begin
    res_nxt = '0;
    case (s4_r.op)
      OP_IDLE: begin
        res_nxt = '0;
      end
      OP_START: begin
        res_nxt.busy_res = 1'b1;
      end
      OP_IGNORE: begin
        res_nxt.busy_res      = 1'b1;
        res_nxt.start_ignored = 1'b1;
      end
      OP_UNIT: begin
        res_nxt.busy_res  = 1'b1;
        res_nxt.frame_end = s4_r.last;
        // Manchester-like cell: not-b, b, b, not-b
        if (!s4_r.quiet) begin
          res_nxt.line_level = (s4_r.pos[1] ^ s4_r.pos[0]) ? data_bit : ~data_bit;
        end
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_v_r      <= q_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      s4_r  <= s4_nxt;
      res_r <= res_nxt;
      if (s4_v_r && s4_r.op == OP_START) begin
        frame_r <= frame_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.frame_end) |-> res_r.busy_res)
    else $error("frame end without busy");

  a_ignored_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.start_ignored) |-> (res_r.busy_res && !res_r.line_level))
    else $error("dropped start drove the line");

  a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.busy_res) |-> !res_r.line_level)
    else $error("line driven while idle");

  a_pipe_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s4_v_r) |=> out_valid_r)
    else $error("item lost between pipeline and output");

endmodule

FILE: sv/rf_temperature_frame_encoder_core.sv
// ----------------------------------------------------------------------------
// rf_temperature_frame_encoder_core
// Temperature sensor RF frame encoder: builds a nine-byte frame from a raw
// reading and serializes it one line unit per tick item.
// ----------------------------------------------------------------------------
// Send a start item (action = 1) with a raw reading in 1/16 degree; it is
// clamped to -880..2000, turned into centi-degrees and packed with the
// configured type, channel and id into a nine-byte frame with a nibble
// checksum. Every following tick item (action = 0) returns one line unit:
// a 16-bit ones preamble, the frame LSB first and an 8-bit zero postamble,
// four units per bit (not-b, b, b, not-b), then PAUSE_UNITS low units and
// the same message again, 768 + PAUSE_UNITS units in total, frame_end marking
// the last one. A start while busy is dropped and flagged by start_ignored.
// Every item returns exactly one result item. Rate: one item per clock,
// sustained while out_ch.ready is high; an accepted item is written to the
// queue, read into arithmetic stage one, passes through stages two to four
// and then loads the output register that drives out_ch. Throughput is
// bounded only by the output handshake: when out_ch.ready is low the back
// pipeline holds and the queue fills, then in_ch.ready drops. Configuration
// (byte addresses 0, 4, 8, 12) is picked up when a start item reaches the
// frame store, so write it only while the block is idle. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module rf_temperature_frame_encoder_core import rtfe_pkg::*; #(
  parameter int unsigned PAUSE_UNITS = PAUSE_UNITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  rtfe_in_if.sink            in_ch,
  rtfe_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t     cfg;
  logic     push_valid, push_ready;
  q_entry_t push_entry;
  logic     pop_valid, pop_ready;
  q_entry_t pop_entry;
  logic     res_valid;
  res_t     res;

  // register file
  rtfe_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front: owns the transmit position, decides what each item means
  rtfe_front #(
    .PAUSE_UNITS (PAUSE_UNITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_action  (in_ch.action),
    .in_reading (in_ch.sensor_reading),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  // decoupling queue
  rtfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // back: frame arithmetic, frame store, serializer, output register
  rtfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_entry   (pop_entry),
    .out_valid (res_valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.valid         = res_valid;
  assign out_ch.line_level    = res.line_level;
  assign out_ch.busy_res      = res.busy_res;
  assign out_ch.frame_end     = res.frame_end;
  assign out_ch.start_ignored = res.start_ignored;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RF temperature frame encoder core. A local
// frame builder and line serializer predict one result per accepted item;
// results are compared field by field in arrival order. Directed runs cover
// reset and all-ones register settings, clamping at both limits, sign
// handling, starts while busy and a long output stall; random traffic
// follows with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb import rtfe_pkg::*;;

  localparam int unsigned PAUSE        = PAUSE_UNITS_DEF;
  localparam int unsigned TOTAL_UNITS  = 2 * MSG_UNITS + PAUSE;
  localparam int          RESET_CYCLES = 6;
  localparam int          LONG_GAP_MAX = 30;
  localparam int          STALL_CYCLES = 150;   // long receiver hold-off
  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          RAND_ITEMS   = 70;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_START = 1'b1
  } action_t;

  logic clk = 1'b0;
  logic rst_n;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  rtfe_in_if  in_ch ();
  rtfe_out_if out_ch ();

  rf_temperature_frame_encoder_core #(
    .PAUSE_UNITS (PAUSE)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Local copy of the encoder: register shadow, frame bytes, line position
  cfg_t        cfg_now;
  logic [7:0]  frame_bytes [FRAME_BYTES];
  int unsigned unit_pos;
  bit          tx_active;

  res_t line_unit_q [$];   // expected results, oldest first

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int stall_req      = 0;  // receiver hold-off request, in cycles
  bit src_idle_on    = 1'b1;
  bit sink_idle_on   = 1'b1;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Clamp, convert to centi-degrees and lay out the nine frame bytes
  function automatic void pack_frame(logic signed [READING_W-1:0] raw);
    int r;
    int m;
    int centi;
    int whole;
    int tenths;
    int nib_sum;
    bit neg;
    r = raw;
    if (r < READING_MIN) r = READING_MIN;
    if (r > READING_MAX) r = READING_MAX;
    neg    = (r < 0);
    m      = neg ? -r : r;
    centi  = 6 * m + m / 4;
    whole  = centi / 100;
    tenths = (centi % 100 + 5) / 10;
    frame_bytes[0] = cfg_now.sensor_type[15:8];
    frame_bytes[1] = cfg_now.sensor_type[7:0];
    frame_bytes[2] = cfg_now.channel_code;
    frame_bytes[3] = cfg_now.rolling_id;
    frame_bytes[4] = {4'(tenths), cfg_now.battery_ok ? 4'h0 : BATT_LOW_NIBBLE};
    frame_bytes[5] = {4'(whole / 10), 4'(whole % 10)};   // tens may reach 12
    frame_bytes[6] = neg ? NEG_MARK : 8'h00;
    frame_bytes[7] = 8'h00;
    nib_sum = 0;
    for (int i = 0; i < FRAME_BYTES - 1; i++)
      nib_sum += int'(frame_bytes[i][7:4]) + int'(frame_bytes[i][3:0]);
    frame_bytes[FRAME_BYTES-1] = 8'(nib_sum - CHECK_BIAS);
  endfunction

  // Line level of unit p within one message: four units per bit
  function automatic logic message_unit_level(int unsigned p);
    int unsigned bit_idx;
    int unsigned phase;
    int unsigned k;
    logic b;
    bit_idx = p / 4;
    phase   = p % 4;
    if (bit_idx < PREAMBLE_BITS) begin
      b = 1'b1;
    end else if (bit_idx < PREAMBLE_BITS + FRAME_BITS) begin
      k = bit_idx - PREAMBLE_BITS;
      b = frame_bytes[k / 8][k % 8];   // LSB first
    end else begin
      b = 1'b0;
    end
    return (phase == 1 || phase == 2) ? b : ~b;
  endfunction

  function automatic res_t next_line_unit(action_t act, logic signed [READING_W-1:0] rd);
    res_t r = '0;
    if (act == ACT_START) begin
      r.busy_res = 1'b1;
      if (tx_active) begin
        r.start_ignored = 1'b1;
      end else begin
        pack_frame(rd);
        tx_active = 1'b1;
        unit_pos  = 0;
      end
    end else if (tx_active) begin
      r.busy_res = 1'b1;
      if (unit_pos < MSG_UNITS)
        r.line_level = message_unit_level(unit_pos);
      else if (unit_pos >= MSG_UNITS + PAUSE)
        r.line_level = message_unit_level(unit_pos - MSG_UNITS - PAUSE);
      if (unit_pos + 1 >= TOTAL_UNITS) begin
        r.frame_end = 1'b1;
        tx_active   = 1'b0;
        unit_pos    = 0;
      end else begin
        unit_pos++;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  function automatic void check_field(string field, logic want, logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (line_unit_q.size() == 0) begin
        $display("%0t: unexpected result item, expected none, got %0b%0b%0b%0b", $time,
                 out_ch.line_level, out_ch.busy_res, out_ch.frame_end,
                 out_ch.start_ignored);
        mismatch_count++;
      end else begin
        want = line_unit_q.pop_front();
        check_field("line_level",    want.line_level,    out_ch.line_level);
        check_field("busy_res",      want.busy_res,      out_ch.busy_res);
        check_field("frame_end",     want.frame_end,     out_ch.frame_end);
        check_field("start_ignored", want.start_ignored, out_ch.start_ignored);
      end
    end
  end

  // Ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** rf_temperature_frame_encoder_core: FAILED **");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap(bit on);
    int roll;
    if (!on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, LONG_GAP_MAX);
  endfunction

  // Result receiver: random ready gaps, plus a hold-off on request
  initial begin : result_sink
    int gap;
    int run;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (stall_req > 0) begin
        run = stall_req;
        stall_req = 0;
        out_ch.ready <= 1'b0;
        repeat (run) @(posedge clk);
      end else begin
        gap = pick_gap(sink_idle_on);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      run = $urandom_range(1, 8);
      repeat (run) @(posedge clk);
    end
  end

  // Offer one item and predict its result once accepted. valid is left high
  // so back-to-back items do not drop it in between.
  task automatic send_item(action_t act, logic signed [READING_W-1:0] rd);
    int gap;
    gap = pick_gap(src_idle_on);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= act;
    in_ch.sensor_reading <= rd;
    do @(posedge clk); while (!in_ch.ready);
    line_unit_q.push_back(next_line_unit(act, rd));
  endtask

  // Stop offering and wait for every outstanding result
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (line_unit_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Only called with no item in flight
  task automatic write_cfg(cfg_t c);
    write_reg(REG_SENSOR_TYPE,  PDATA_W'(c.sensor_type));
    write_reg(REG_CHANNEL_CODE, PDATA_W'(c.channel_code));
    write_reg(REG_ROLLING_ID,   PDATA_W'(c.rolling_id));
    write_reg(REG_BATTERY_OK,   PDATA_W'(c.battery_ok));
    cfg_now = c;
  endtask

  // Start item followed by ticks up to the final unit. With busy_starts set,
  // extra starts land on the first unit, the end of the first message, the
  // first unit of the repeat and the last unit.
  task automatic run_transmission(logic signed [READING_W-1:0] rd, bit busy_starts);
    send_item(ACT_START, rd);
    while (tx_active) begin
      if (busy_starts && unit_pos inside {0, MSG_UNITS - 1, MSG_UNITS + PAUSE,
                                          TOTAL_UNITS - 1})
        send_item(ACT_START, READING_W'($urandom));
      send_item(ACT_TICK, READING_W'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Ticks with nothing to send give all-zero results
  task automatic test_idle_ticks();
    repeat (4) send_item(ACT_TICK, READING_W'($urandom));
  endtask

  // Register reset values, a reading clamped at the top (tens nibble 12) and
  // starts while busy, which are dropped
  task automatic test_start_while_busy();
    run_transmission(12'sh7FF, 1'b1);
  endtask

  // All-ones registers, a negative reading clamped at the bottom; the
  // receiver holds off while the sender keeps offering ticks
  task automatic test_output_stall();
    settle();
    write_cfg('{sensor_type: 16'hFFFF, channel_code: 8'hFF, rolling_id: 8'hFF,
                battery_ok: 1'b1});
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    stall_req    = STALL_CYCLES;
    run_transmission(12'sh800, 1'b0);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Random starts and ticks with a fresh random register setting; the last
  // transmission may be left unfinished
  task automatic test_random_traffic();
    cfg_t c;
    bit go;
    settle();
    c.sensor_type  = 16'($urandom);
    c.channel_code = 8'($urandom);
    c.rolling_id   = 8'($urandom);
    c.battery_ok   = 1'($urandom);
    write_cfg(c);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 32 == 0) begin
        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
      end
      if (tx_active)
        go = ($urandom_range(0, 99) < 2);
      else
        go = ($urandom_range(0, 99) < 35);
      send_item(go ? ACT_START : ACT_TICK, READING_W'($urandom));
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.action         = ACT_TICK;
    in_ch.sensor_reading = '0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    cfg_now   = '{SENSOR_TYPE_RST, CHANNEL_CODE_RST, ROLLING_ID_RST, BATTERY_OK_RST};
    tx_active = 1'b0;
    unit_pos  = 0;
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_start_while_busy();
    test_output_stall();
    test_random_traffic();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("** rf_temperature_frame_encoder_core: PASSED **");
    else
      $display("** rf_temperature_frame_encoder_core: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
sv/rtfe_pkg.sv
sv/rtfe_in_if.sv
sv/rtfe_out_if.sv
sv/rtfe_cfg_regs.sv
sv/rtfe_front.sv
sv/rtfe_queue.sv
sv/rtfe_back.sv
sv/rf_temperature_frame_encoder_core.sv
sim/tb.sv
